### rtl/slpd_pkg.sv
// slpd_pkg: shared types, constants and sensor tables for the sensor link decoder
// no dependencies; used by every module of the block by scoped names
package slpd_pkg;

    localparam int NUM_SLOTS        = 4;
    localparam int NUM_SENSOR_TYPES = 7;
    localparam int SLOT_IDX_W       = $clog2(NUM_SLOTS);
    localparam int TYPE_W           = 3;
    localparam int ANGLE_W          = 12;
    localparam int VALUE_W          = 23;
    localparam int GRAD_W           = 14;
    localparam int ICPT_W           = 9;
    localparam int PROD_W           = ANGLE_W + GRAD_W;

    // byte position counter: 0..3 capture, IDLE_POS idle
    localparam logic [2:0] IDLE_POS = 3'd4;
    localparam logic [2:0] LAST_POS = 3'd3;

    localparam logic [7:0] CHR_DIGIT_LO = 8'h30;
    localparam logic [7:0] CHR_DIGIT_HI = 8'h39;
    localparam logic [7:0] CHR_UPPER_LO = 8'h41;
    localparam logic [7:0] CHR_UPPER_HI = 8'h46;
    localparam logic [3:0] NIB_LETTER   = 4'h4;

    // angle*grad*256/2352 = angle*grad*16/147; 147 via reciprocal, exact for N < 2^27
    localparam int          RECIP_SHIFT = 38 - 4;
    localparam logic [30:0] RECIP       = 31'd1869917735;
    localparam int          WIDE_W      = PROD_W + 31;
    localparam int          QUOT_W      = 22;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [TYPE_W-1:0] SLOT_RESET [NUM_SLOTS] = '{3'd6, 3'd5, 3'd3, 3'd0};

    typedef struct packed {
        logic [SLOT_IDX_W-1:0] slot;
        logic [TYPE_W-1:0]     stype;
        logic                  valid;
        logic [ANGLE_W-1:0]    angle;
    } t_job;

    typedef struct packed {
        logic                  valid;
        logic [SLOT_IDX_W-1:0] index;
        logic [TYPE_W-1:0]     data;
    } t_cfg_wr;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PROD,
        BK_SCALE,
        BK_OUT
    } t_back_state;

    function automatic logic type_ok(input logic [TYPE_W-1:0] t);
        return 32'(t) < NUM_SENSOR_TYPES;
    endfunction

    function automatic logic [3:0] type_id(input logic [TYPE_W-1:0] t);
        logic [3:0] id;
        unique case (t)
            3'd0:    id = 4'h1;
            3'd1:    id = 4'h2;
            3'd2:    id = 4'h3;
            3'd3:    id = 4'h4;
            3'd4:    id = 4'h5;
            3'd5:    id = 4'h7;
            3'd6:    id = 4'hF;
            default: id = 4'h0;
        endcase
        return id;
    endfunction

    function automatic logic [GRAD_W-1:0] type_grad(input logic [TYPE_W-1:0] t);
        logic [GRAD_W-1:0] g;
        unique case (t)
            3'd0:    g = 14'd3;
            3'd1:    g = 14'd9000;
            3'd2:    g = 14'd10;
            3'd3:    g = 14'd6;
            3'd4:    g = 14'd900;
            3'd5:    g = 14'd100;
            3'd6:    g = 14'd100;
            default: g = '0;
        endcase
        if (!type_ok(t)) begin
            g = '0;
        end
        return g;
    endfunction

    function automatic logic signed [ICPT_W-1:0] type_icpt(input logic [TYPE_W-1:0] t);
        logic signed [ICPT_W-1:0] c;
        unique case (t)
            3'd0:    c = -9'sd1;
            3'd1:    c = 9'sd0;
            3'd2:    c = 9'sd0;
            3'd3:    c = 9'sd0;
            3'd4:    c = 9'sd200;
            3'd5:    c = 9'sd50;
            3'd6:    c = 9'sd20;
            default: c = '0;
        endcase
        if (!type_ok(t)) begin
            c = '0;
        end
        return c;
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= CHR_DIGIT_LO && c <= CHR_DIGIT_HI) ||
               (c >= CHR_UPPER_LO && c <= CHR_UPPER_HI);
    endfunction

    function automatic logic [3:0] digit_value(input logic [7:0] c);
        return (c[7:4] == NIB_LETTER) ? 4'(c[3:0] + 4'd9) : c[3:0];
    endfunction

endpackage

### rtl/sensor_link_packet_decoder.sv
// sensor_link_packet_decoder: top level of the gauge sensor link packet decoder
// throughput: one byte per cycle while full is low; the scaling back end works one packet
// at a time (queue pop, product, reciprocal multiply, output load), a packet spans at least 5 bytes
// reset: synchronous active low; slot registers return to 6,5,3,0, capture goes idle,
// the job queue and the output register empty
module sensor_link_packet_decoder (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [7:0]                          i_rx_byte,
    output logic                                empty,
    input  logic                                pop,
    output logic [slpd_pkg::SLOT_IDX_W-1:0]     o_slot,
    output logic [slpd_pkg::TYPE_W-1:0]         o_sensor_type,
    output logic                                o_packet_valid,
    output logic [slpd_pkg::ANGLE_W-1:0]        o_angle,
    output logic signed [slpd_pkg::VALUE_W-1:0] o_scaled_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [slpd_pkg::SLOT_IDX_W-1:0]     i_cfg_index,
    input  logic [slpd_pkg::TYPE_W-1:0]         i_cfg_data
);

    slpd_pkg::t_cfg_wr w_cfg;
    slpd_pkg::t_job    w_push_job;
    slpd_pkg::t_job    w_head_job;
    logic              w_job_push;
    logic              w_q_pop;
    logic              w_q_empty;
    logic              w_accept;

    assign o_cfg_ready = 1'b1;
    assign w_cfg.valid = i_cfg_valid;
    assign w_cfg.index = i_cfg_index;
    assign w_cfg.data  = i_cfg_data;
    assign w_accept    = push && !full;

    slpd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_rx_byte  (i_rx_byte),
        .i_cfg      (w_cfg),
        .o_job_push (w_job_push),
        .o_job      (w_push_job)
    );

    // input stalls only when the job queue is full
    slpd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_job_push),
        .i_job   (w_push_job),
        .i_pop   (w_q_pop),
        .o_full  (full),
        .o_empty (w_q_empty),
        .o_job   (w_head_job)
    );

    slpd_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (w_q_empty),
        .i_job          (w_head_job),
        .o_q_pop        (w_q_pop),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_slot         (o_slot),
        .o_sensor_type  (o_sensor_type),
        .o_packet_valid (o_packet_valid),
        .o_angle        (o_angle),
        .o_scaled_value (o_scaled_value)
    );

endmodule

### rtl/slpd_front.sv
// slpd_front: byte classifier, slot registers, id match and packet capture
// depends on slpd_pkg; pushes finished packets as jobs into slpd_queue
module slpd_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_accept,
    input  logic [7:0]             i_rx_byte,
    input  slpd_pkg::t_cfg_wr      i_cfg,
    output logic                   o_job_push,
    output slpd_pkg::t_job         o_job
);

    logic [slpd_pkg::TYPE_W-1:0]     r_slot_sensor [slpd_pkg::NUM_SLOTS];
    logic [slpd_pkg::SLOT_IDX_W-1:0] r_active_slot;
    logic [slpd_pkg::SLOT_IDX_W-1:0] n_active_slot;
    logic [2:0]                      r_pos;
    logic [2:0]                      n_pos;
    logic [7:0]                      r_digit [2];

    logic                            w_is_id;
    logic                            w_found;
    logic [slpd_pkg::SLOT_IDX_W-1:0] w_match_slot;
    logic                            w_capture;
    logic                            w_valid;

    assign w_is_id   = (i_rx_byte[7:4] == 4'h0);
    assign w_capture = i_accept && !w_is_id && (r_pos < slpd_pkg::IDLE_POS);

    // first matching slot wins
    always_comb begin
        w_found      = 1'b0;
        w_match_slot = '0;
        for (int i = 0; i < slpd_pkg::NUM_SLOTS; i++) begin
            if (!w_found && slpd_pkg::type_ok(r_slot_sensor[i]) &&
                slpd_pkg::type_id(r_slot_sensor[i]) == i_rx_byte[3:0]) begin
                w_found      = 1'b1;
                w_match_slot = slpd_pkg::SLOT_IDX_W'(i);
            end
        end
    end

    always_comb begin
        n_active_slot = r_active_slot;
        n_pos         = r_pos;
        if (i_accept && w_is_id && w_found) begin
            n_active_slot = w_match_slot;
            n_pos         = 3'd0;
        end else if (w_capture) begin
            n_pos = (r_pos == slpd_pkg::LAST_POS) ? slpd_pkg::IDLE_POS : 3'(r_pos + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_slot <= '0;
            r_pos         <= slpd_pkg::IDLE_POS;
        end else begin
            r_active_slot <= n_active_slot;
            r_pos         <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_sensor <= slpd_pkg::SLOT_RESET;
        end else if (i_cfg.valid) begin
            r_slot_sensor[i_cfg.index] <= i_cfg.data;
        end
    end

    // first two digits are held; the third comes straight from the bus
    always_ff @(posedge i_clk) begin
        if (w_capture && r_pos == 3'd1) begin
            r_digit[0] <= i_rx_byte;
        end
        if (w_capture && r_pos == 3'd2) begin
            r_digit[1] <= i_rx_byte;
        end
    end

    assign w_valid = slpd_pkg::is_hex(r_digit[0]) && slpd_pkg::is_hex(r_digit[1]) &&
                     slpd_pkg::is_hex(i_rx_byte);

    assign o_job_push  = w_capture && (r_pos == slpd_pkg::LAST_POS);
    assign o_job.slot  = r_active_slot;
    assign o_job.stype = r_slot_sensor[r_active_slot];
    assign o_job.valid = w_valid;
    assign o_job.angle = w_valid ? {slpd_pkg::digit_value(r_digit[0]),
                                    slpd_pkg::digit_value(r_digit[1]),
                                    slpd_pkg::digit_value(i_rx_byte)} : '0;

endmodule

### rtl/slpd_queue.sv
// slpd_queue: short job queue between the capture front and the scaling back
// depends on slpd_pkg for the job type and depth
module slpd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  slpd_pkg::t_job  i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output slpd_pkg::t_job  o_job
);

    slpd_pkg::t_job              r_mem [slpd_pkg::QDEPTH];
    logic [slpd_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [slpd_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [slpd_pkg::QCNT_W-1:0] r_count;
    logic                        w_do_push;
    logic                        w_do_pop;

    assign o_full    = (32'(r_count) == slpd_pkg::QDEPTH);
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_job     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (32'(r_wr_ptr) == slpd_pkg::QDEPTH - 1) ? '0 :
                            slpd_pkg::QPTR_W'(r_wr_ptr + 1'b1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (32'(r_rd_ptr) == slpd_pkg::QDEPTH - 1) ? '0 :
                            slpd_pkg::QPTR_W'(r_rd_ptr + 1'b1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= slpd_pkg::QCNT_W'(r_count + 1'b1);
            end else if (w_do_pop && !w_do_push) begin
                r_count <= slpd_pkg::QCNT_W'(r_count - 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

### rtl/slpd_back.sv
// slpd_back: per-type scaling of the angle and the result output register
// depends on slpd_pkg; takes jobs from slpd_queue
module slpd_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_empty,
    input  slpd_pkg::t_job                      i_job,
    output logic                                o_q_pop,
    input  logic                                i_pop,
    output logic                                o_empty,
    output logic [slpd_pkg::SLOT_IDX_W-1:0]     o_slot,
    output logic [slpd_pkg::TYPE_W-1:0]         o_sensor_type,
    output logic                                o_packet_valid,
    output logic [slpd_pkg::ANGLE_W-1:0]        o_angle,
    output logic signed [slpd_pkg::VALUE_W-1:0] o_scaled_value
);

    slpd_pkg::t_back_state           r_state;
    slpd_pkg::t_back_state           n_state;
    slpd_pkg::t_job                  r_job;
    logic [slpd_pkg::PROD_W-1:0]     r_prod;
    logic [slpd_pkg::QUOT_W-1:0]     r_quot;
    logic                            r_out_full;
    logic                            w_load_out;
    logic                            w_take;
    logic [slpd_pkg::WIDE_W-1:0]     w_wide;
    logic signed [slpd_pkg::ICPT_W-1:0]  w_icpt;
    logic signed [slpd_pkg::VALUE_W-1:0] w_value;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            slpd_pkg::BK_IDLE:  if (!i_q_empty) n_state = slpd_pkg::BK_PROD;
            slpd_pkg::BK_PROD:  n_state = slpd_pkg::BK_SCALE;
            slpd_pkg::BK_SCALE: n_state = slpd_pkg::BK_OUT;
            slpd_pkg::BK_OUT:   if (!r_out_full || i_pop) n_state = slpd_pkg::BK_IDLE;
            default:            n_state = slpd_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        w_load_out = 1'b0;
        unique case (r_state)
            slpd_pkg::BK_IDLE: o_q_pop    = !i_q_empty;
            slpd_pkg::BK_OUT:  w_load_out = !r_out_full || i_pop;
            default: begin
            end
        endcase
    end

    assign w_take = i_pop && r_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= slpd_pkg::BK_IDLE;
            r_out_full <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_full <= 1'b1;
            end else if (w_take) begin
                r_out_full <= 1'b0;
            end
        end
    end

    assign w_wide  = slpd_pkg::WIDE_W'(r_prod) * slpd_pkg::WIDE_W'(slpd_pkg::RECIP);
    assign w_icpt  = slpd_pkg::type_icpt(r_job.stype);
    // intercept carries 8 fraction bits
    assign w_value = r_job.valid ?
                     signed'(slpd_pkg::VALUE_W'({1'b0, r_quot})) +
                     slpd_pkg::VALUE_W'(signed'({w_icpt, 8'h00})) : '0;

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_job <= i_job;
        end
        if (r_state == slpd_pkg::BK_PROD) begin
            r_prod <= slpd_pkg::PROD_W'(r_job.angle) *
                      slpd_pkg::PROD_W'(slpd_pkg::type_grad(r_job.stype));
        end
        if (r_state == slpd_pkg::BK_SCALE) begin
            r_quot <= w_wide[slpd_pkg::RECIP_SHIFT +: slpd_pkg::QUOT_W];
        end
        if (w_load_out) begin
            o_slot         <= r_job.slot;
            o_sensor_type  <= r_job.stype;
            o_packet_valid <= r_job.valid;
            o_angle        <= r_job.angle;
            o_scaled_value <= w_value;
        end
    end

    assign o_empty = !r_out_full;

endmodule

### rtl/slpd_checker.sv
// slpd_checker: port-level assertions for the sensor link packet decoder
// depends on slpd_pkg; bound to the top level at the end of this file
module slpd_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                empty,
    input logic                                pop,
    input logic [slpd_pkg::SLOT_IDX_W-1:0]     o_slot,
    input logic [slpd_pkg::TYPE_W-1:0]         o_sensor_type,
    input logic                                o_packet_valid,
    input logic [slpd_pkg::ANGLE_W-1:0]        o_angle,
    input logic signed [slpd_pkg::VALUE_W-1:0] o_scaled_value
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result shown right after reset");

    a_hold_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_scaled_value) && $stable(o_angle) &&
                              $stable(o_slot) && $stable(o_sensor_type)))
        else $error("waiting result word changed before pop");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_packet_valid) |-> (o_angle == '0 && o_scaled_value == '0))
        else $error("invalid packet with nonzero angle or value");

    a_bad_type_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && 32'(o_sensor_type) >= slpd_pkg::NUM_SENSOR_TYPES) |->
        (o_scaled_value == '0))
        else $error("unknown sensor type with nonzero value");

endmodule

bind sensor_link_packet_decoder slpd_checker u_slpd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .empty          (empty),
    .pop            (pop),
    .o_slot         (o_slot),
    .o_sensor_type  (o_sensor_type),
    .o_packet_valid (o_packet_valid),
    .o_angle        (o_angle),
    .o_scaled_value (o_scaled_value)
);

### verif/sensor_link_packet_decoder_tb.sv
// sensor_link_packet_decoder_tb: self-checking bench for the sensor link packet decoder
// drives link bytes and slot register writes, predicts each packet reading and checks it
// depends on slpd_pkg and sensor_link_packet_decoder
`timescale 1ns / 100ps

module sensor_link_packet_decoder_tb;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int RANDOM_WORDS = 600;
    localparam int SETTLE       = 16;
    localparam int FULL_SCALE   = 2352;

    localparam logic [slpd_pkg::SLOT_IDX_W-1:0] SLOT0_REG = 2'd0;
    localparam logic [slpd_pkg::SLOT_IDX_W-1:0] SLOT1_REG = 2'd1;
    localparam logic [slpd_pkg::SLOT_IDX_W-1:0] SLOT2_REG = 2'd2;
    localparam logic [slpd_pkg::SLOT_IDX_W-1:0] SLOT3_REG = 2'd3;

    // per sensor type: link id, gradient, intercept
    localparam logic [3:0] SENSOR_ID   [slpd_pkg::NUM_SENSOR_TYPES] =
        '{4'h1, 4'h2, 4'h3, 4'h4, 4'h5, 4'h7, 4'hF};
    localparam int         SENSOR_GRAD [slpd_pkg::NUM_SENSOR_TYPES] =
        '{3, 9000, 10, 6, 900, 100, 100};
    localparam int         SENSOR_OFFS [slpd_pkg::NUM_SENSOR_TYPES] =
        '{-1, 0, 0, 0, 200, 50, 20};

    typedef struct packed {
        logic [slpd_pkg::SLOT_IDX_W-1:0]     slot;
        logic [slpd_pkg::TYPE_W-1:0]         stype;
        logic                                valid;
        logic [slpd_pkg::ANGLE_W-1:0]        angle;
        logic signed [slpd_pkg::VALUE_W-1:0] value;
    } t_reading;

    logic                                i_clk        = 1'b0;
    logic                                i_rst_n      = 1'b0;
    logic                                push         = 1'b0;
    logic [7:0]                          i_rx_byte    = 8'h00;
    logic                                pop          = 1'b0;
    logic                                i_cfg_valid  = 1'b0;
    logic [slpd_pkg::SLOT_IDX_W-1:0]     i_cfg_index  = '0;
    logic [slpd_pkg::TYPE_W-1:0]         i_cfg_data   = '0;
    logic                                full;
    logic                                empty;
    logic [slpd_pkg::SLOT_IDX_W-1:0]     o_slot;
    logic [slpd_pkg::TYPE_W-1:0]         o_sensor_type;
    logic                                o_packet_valid;
    logic [slpd_pkg::ANGLE_W-1:0]        o_angle;
    logic signed [slpd_pkg::VALUE_W-1:0] o_scaled_value;
    logic                                o_cfg_ready;

    // stimulus side
    logic [7:0]                  link_bytes [$];
    logic [slpd_pkg::TYPE_W-1:0] planned_type [slpd_pkg::NUM_SLOTS] =
        '{3'd6, 3'd5, 3'd3, 3'd0};
    bit                          no_idle = 1'b0;
    int                          traffic_words = 0;
    int                          send_gap = 0;
    int                          pop_stall = 0;

    // decoder prediction
    t_reading                        readings_due [$];
    logic [slpd_pkg::TYPE_W-1:0]     slot_type [slpd_pkg::NUM_SLOTS];
    logic [slpd_pkg::SLOT_IDX_W-1:0] cap_slot;
    logic [2:0]                      cap_pos;
    logic [7:0]                      cap_digits [3];

    int fail_count = 0;
    int words_taken = 0;
    int readings_checked = 0;
    int invalid_checked = 0;
    int cfg_writes = 0;
    int cycle_count = 0;

    sensor_link_packet_decoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_rx_byte      (i_rx_byte),
        .empty          (empty),
        .pop            (pop),
        .o_slot         (o_slot),
        .o_sensor_type  (o_sensor_type),
        .o_packet_valid (o_packet_valid),
        .o_angle        (o_angle),
        .o_scaled_value (o_scaled_value),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit is_hex_char(input logic [7:0] c);
        return (c >= slpd_pkg::CHR_DIGIT_LO && c <= slpd_pkg::CHR_DIGIT_HI) ||
               (c >= slpd_pkg::CHR_UPPER_LO && c <= slpd_pkg::CHR_UPPER_HI);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        return (c[7:4] == slpd_pkg::NIB_LETTER) ? 4'(c[3:0] + 4'd9) : c[3:0];
    endfunction

    function automatic logic [7:0] hex_char();
        int d;
        d = $urandom_range(0, 15);
        return (d < 10) ? 8'(slpd_pkg::CHR_DIGIT_LO + d) : 8'(slpd_pkg::CHR_UPPER_LO + d - 10);
    endfunction

    // any non-id byte that is not an uppercase hex digit
    function automatic logic [7:0] bad_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(16, 255));
        end while (is_hex_char(c));
        return c;
    endfunction

    // mostly an id some slot watches, now and then any id
    function automatic logic [7:0] pick_id();
        int s;
        s = $urandom_range(0, slpd_pkg::NUM_SLOTS - 1);
        if (planned_type[s] < slpd_pkg::NUM_SENSOR_TYPES && $urandom_range(0, 6) != 0) begin
            return {4'h0, SENSOR_ID[planned_type[s]]};
        end
        return 8'($urandom_range(0, 15));
    endfunction

    task automatic decode_link_byte(input logic [7:0] b);
        t_reading                    r;
        logic [slpd_pkg::TYPE_W-1:0] t;
        bit                          found;
        longint                      scaled;
        found = 1'b0;
        if (b[7:4] == 4'h0) begin
            for (int s = 0; s < slpd_pkg::NUM_SLOTS; s++) begin
                if (!found && slot_type[s] < slpd_pkg::NUM_SENSOR_TYPES) begin
                    if (SENSOR_ID[slot_type[s]] == b[3:0]) begin
                        found = 1'b1;
                        cap_slot = slpd_pkg::SLOT_IDX_W'(s);
                        cap_pos = 3'd0;
                    end
                end
            end
        end else if (cap_pos < slpd_pkg::IDLE_POS) begin
            if (cap_pos != 3'd0) cap_digits[cap_pos - 3'd1] = b;
            if (cap_pos < slpd_pkg::LAST_POS) begin
                cap_pos = cap_pos + 3'd1;
            end else begin
                cap_pos = slpd_pkg::IDLE_POS;
                t = slot_type[cap_slot];
                r.slot  = cap_slot;
                r.stype = t;
                r.valid = is_hex_char(cap_digits[0]) && is_hex_char(cap_digits[1]) &&
                          is_hex_char(cap_digits[2]);
                r.angle = '0;
                scaled  = 0;
                if (r.valid) begin
                    r.angle = {nibble_of(cap_digits[0]), nibble_of(cap_digits[1]),
                               nibble_of(cap_digits[2])};
                    if (t < slpd_pkg::NUM_SENSOR_TYPES) begin
                        scaled = (longint'(r.angle) * SENSOR_GRAD[t] * 256) / FULL_SCALE
                                 + SENSOR_OFFS[t] * 256;
                    end
                end
                r.value = scaled[slpd_pkg::VALUE_W-1:0];
                readings_due.push_back(r);
            end
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    task automatic check_reading();
        t_reading want;
        if (readings_due.size() == 0) begin
            $error("word with no reading due: slot %0d angle %0d", o_slot, o_angle);
            fail_count++;
        end else begin
            want = readings_due.pop_front();
            check_field("slot", int'(want.slot), int'(o_slot));
            check_field("sensor_type", int'(want.stype), int'(o_sensor_type));
            check_field("packet_valid", int'(want.valid), int'(o_packet_valid));
            check_field("angle", int'(want.angle), int'(o_angle));
            check_field("scaled_value", int'($signed(want.value)), int'(o_scaled_value));
            readings_checked++;
            if (!want.valid) invalid_checked++;
        end
    endtask

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
            send_gap = 0;
        end else if (!(push && full)) begin
            if (send_gap > 0) begin
                push <= 1'b0;
                send_gap--;
            end else if (link_bytes.size() != 0) begin
                push <= 1'b1;
                i_rx_byte <= link_bytes.pop_front();
                send_gap = no_idle ? 0 : pick_gap();
            end else begin
                push <= 1'b0;
            end
        end
    end

    // result sink stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
            pop_stall = 0;
        end else if (pop_stall > 0) begin
            pop <= 1'b0;
            pop_stall--;
        end else begin
            pop <= 1'b1;
            if (!no_idle && $urandom_range(0, 3) == 0) pop_stall = pick_gap();
        end
    end

    // monitor: tracks register writes and accepted bytes, checks popped readings
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            slot_type = slpd_pkg::SLOT_RESET;
            cap_slot  = '0;
            cap_pos   = slpd_pkg::IDLE_POS;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                slot_type[i_cfg_index] = i_cfg_data;
                cfg_writes++;
            end
            if (push && !full) begin
                decode_link_byte(i_rx_byte);
                words_taken++;
            end
            if (pop && !empty) check_reading();
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d readings due", cycle_count,
                     readings_due.size());
            $display("simulation failed");
            $finish;
        end
    end

    task automatic write_slot_reg(input logic [slpd_pkg::SLOT_IDX_W-1:0] idx,
                                  input logic [slpd_pkg::TYPE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        planned_type[idx] = val;
    endtask

    task automatic set_slots(input logic [slpd_pkg::TYPE_W-1:0] t0,
                             input logic [slpd_pkg::TYPE_W-1:0] t1,
                             input logic [slpd_pkg::TYPE_W-1:0] t2,
                             input logic [slpd_pkg::TYPE_W-1:0] t3);
        write_slot_reg(SLOT0_REG, t0);
        write_slot_reg(SLOT1_REG, t1);
        write_slot_reg(SLOT2_REG, t2);
        write_slot_reg(SLOT3_REG, t3);
    endtask

    task automatic wait_drained();
        while (link_bytes.size() != 0 || push || readings_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic push_bytes(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c,
                              input logic [7:0] d, input logic [7:0] e);
        link_bytes.push_back(a);
        link_bytes.push_back(b);
        link_bytes.push_back(c);
        link_bytes.push_back(d);
        link_bytes.push_back(e);
    endtask

    task automatic queue_traffic(input int n);
        int start_len;
        int kind;
        start_len = link_bytes.size();
        while (link_bytes.size() - start_len < n) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                link_bytes.push_back(pick_id());
                link_bytes.push_back(8'($urandom_range(16, 255)));
                repeat (3) begin
                    link_bytes.push_back(($urandom_range(0, 9) == 0) ? bad_char() : hex_char());
                end
            end else if (kind < 80) begin
                // capture cut short by the next id
                link_bytes.push_back(pick_id());
                link_bytes.push_back(8'($urandom_range(16, 255)));
                repeat ($urandom_range(0, 2)) link_bytes.push_back(hex_char());
            end else if (kind < 90) begin
                // stray id in the middle of the digits
                link_bytes.push_back(pick_id());
                link_bytes.push_back(8'($urandom_range(16, 255)));
                link_bytes.push_back(hex_char());
                link_bytes.push_back(8'($urandom_range(0, 15)));
                link_bytes.push_back(hex_char());
                link_bytes.push_back(hex_char());
            end else begin
                repeat ($urandom_range(1, 4)) link_bytes.push_back(8'($urandom_range(0, 255)));
            end
        end
        traffic_words += link_bytes.size() - start_len;
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset slot types 6,5,3,0 watch ids 0f, 07, 04, 01
        link_bytes.push_back(8'hA5);                         // non-id while idle
        push_bytes(8'h01, 8'h10, "0", "0", "0");             // lowest value
        push_bytes(8'h0F, 8'hFF, "F", "F", "F");             // full scale angle
        push_bytes(8'h07, 8'h80, "1", 8'h02, "2");           // unmatched id mid capture
        link_bytes.push_back(8'h60);                         // bad digit
        push_bytes(8'h04, 8'h20, "A", 8'h01, 8'h30);         // restart on matching id
        link_bytes.push_back("9");
        link_bytes.push_back("0");
        link_bytes.push_back("F");
        queue_traffic(90);
        wait_drained();

        // type 1 reaches the top of the value range, type 4 has the big intercept
        set_slots(3'd1, 3'd4, 3'd2, 3'd7);
        push_bytes(8'h02, 8'h41, "F", "F", "F");
        push_bytes(8'h05, 8'h3F, "8", "0", "0");
        push_bytes(8'h03, 8'h55, "a", "1", "2");
        queue_traffic(90);
        wait_drained();

        set_slots(3'd0, 3'd0, 3'd0, 3'd0);
        no_idle = 1'b1;
        queue_traffic(90);
        wait_drained();

        set_slots(3'd6, 3'd6, 3'd6, 3'd6);
        no_idle = 1'b0;
        queue_traffic(90);
        wait_drained();

        // nothing watched: every id is ignored
        set_slots(3'd7, 3'd7, 3'd7, 3'd7);
        for (int k = 0; k < 16; k++) link_bytes.push_back(8'(k));
        repeat (8) link_bytes.push_back(8'($urandom_range(0, 255)));
        wait_drained();

        // leave a capture open on slot 2, then retire its type before the last digits
        set_slots(3'd2, 3'd3, 3'd4, 3'd5);
        queue_traffic(90);
        link_bytes.push_back(8'h05);
        link_bytes.push_back(8'h77);
        link_bytes.push_back("7");
        wait_drained();
        write_slot_reg(SLOT2_REG, 3'd7);
        link_bytes.push_back("8");
        link_bytes.push_back("9");
        wait_drained();

        while (traffic_words < RANDOM_WORDS) begin
            set_slots(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            no_idle = ($urandom_range(0, 3) == 0);
            queue_traffic(90);
            wait_drained();
        end

        $display("%0d link words taken over %0d register writes", words_taken, cfg_writes);
        $display("%0d packet readings checked, %0d of them flagged invalid",
                 readings_checked, invalid_checked);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### files.f
rtl/slpd_pkg.sv
rtl/slpd_front.sv
rtl/slpd_queue.sv
rtl/slpd_back.sv
rtl/sensor_link_packet_decoder.sv
rtl/slpd_checker.sv
verif/sensor_link_packet_decoder_tb.sv
